>>> rtl/core/gld_pkg.sv
package gld_pkg;

  // Width of the bit store that gathers payload bits.
  localparam int STORE_BITS = 24;
  localparam int HELD_W     = 5;
  localparam int BYTE_W     = 8;
  localparam int MCS_W      = 4;
  localparam logic [MCS_W-1:0] ROOT_MIN = 4'd2;
  localparam logic [MCS_W-1:0] ROOT_MAX = 4'd8;
  localparam int MAX_CODE_BITS_DEF = 12;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_PUSH  = 2'd1,
    OP_PULL  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_TAKEN = 3'd0,
    ST_PIXEL = 3'd1,
    ST_NEED  = 3'd2,
    ST_FULL  = 3'd3,
    ST_END   = 3'd4,
    ST_ERROR = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PIX_ZERO  = 2'd0,
    PIX_CODE  = 2'd1,
    PIX_STACK = 2'd2
  } pix_sel_t;

  typedef enum logic [3:0] {
    DP_IDLE      = 4'd0,
    DP_LATCH     = 4'd1,
    DP_START     = 4'd2,
    DP_PUSH      = 4'd3,
    DP_POP       = 4'd4,
    DP_CLEAR     = 4'd5,
    DP_END       = 4'd6,
    DP_CONSUME   = 4'd7,
    DP_FIRST     = 4'd8,
    DP_EXPAND    = 4'd9,
    DP_WALK_STEP = 4'd10,
    DP_WALK_ROOT = 4'd11,
    DP_FLUSH     = 4'd12
  } dp_op_t;

  typedef struct packed {
    dp_op_t   op;
    logic     set_res;
    status_t  res_code;
    pix_sel_t pix_sel;
    logic     load_out;
  } gld_cmd_t;

  typedef struct packed {
    opcode_t item_op;
    status_t push_status;
    logic    ended;
    logic    done;
    logic    fresh;
    logic    stack_empty;
    logic    stack_full;
    logic    bits_short;
    logic    code_clear;
    logic    code_end;
    logic    code_ge_cc2;
    logic    code_gt_nfc;
    logic    cur_ge_cc;
    logic    self_ptr;
  } gld_stat_t;

endpackage

>>> rtl/core/gld_ram.sv
module gld_ram import gld_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/gld_datapath.sv
module gld_datapath import gld_pkg::*; #(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [MCS_W-1:0]  cfg_wdata,
  input  logic [1:0]        opcode,
  input  logic [BYTE_W-1:0] data_byte,
  input  gld_cmd_t          cmd,
  output gld_stat_t         stat,
  output logic [2:0]        status,
  output logic [BYTE_W-1:0] pixel
);

  localparam int CODE_W = MAX_CODE_BITS;
  localparam int NFC_W  = MAX_CODE_BITS + 1;
  localparam int DEPTH  = 1 << MAX_CODE_BITS;
  localparam logic [NFC_W-1:0] TABLE_TOP = NFC_W'(1) << CODE_W;

  logic [MCS_W-1:0]      min_code_size;
  logic [MCS_W-1:0]      root;
  opcode_t               item_op;
  logic [BYTE_W-1:0]     item_byte;
  logic [STORE_BITS-1:0] bit_store;
  logic [HELD_W-1:0]     bits_held;
  logic [BYTE_W-1:0]     block_bytes_left;
  logic [MCS_W-1:0]      width_now;
  logic [NFC_W-1:0]      next_free_code;
  logic [NFC_W-1:0]      width_limit;
  logic [BYTE_W-1:0]     first_char;
  logic [CODE_W-1:0]     old_code;
  logic [CODE_W-1:0]     exp_code;
  logic [CODE_W-1:0]     cur;
  logic [NFC_W-1:0]      stack_depth;
  logic                  fresh;
  logic                  done;
  logic                  ended;
  status_t               res_status;
  logic [BYTE_W-1:0]     res_pixel;
  logic [2:0]            status_q;
  logic [BYTE_W-1:0]     pixel_q;

  logic [MCS_W-1:0]  root_new;
  logic [NFC_W-1:0]  cc;
  logic [NFC_W-1:0]  cc_new;
  logic [CODE_W-1:0] code_mask;
  logic [CODE_W-1:0] code;
  logic [NFC_W-1:0]  code_x;
  logic              code_eq_nfc;
  logic              store_full;
  status_t           push_status;
  logic [NFC_W-1:0]  nfc_inc;
  logic              consume;

  logic              stk_we;
  logic [BYTE_W-1:0] stk_wdata;
  logic [BYTE_W-1:0] stk_rdata;
  logic              tbl_we;
  logic [CODE_W-1:0] pre_rdata;
  logic [BYTE_W-1:0] suf_rdata;

  always_comb begin
    if (min_code_size < ROOT_MIN) begin
      root_new = ROOT_MIN;
    end else if (min_code_size > ROOT_MAX) begin
      root_new = ROOT_MAX;
    end else begin
      root_new = min_code_size;
    end
  end

  assign cc          = NFC_W'(1) << root;
  assign cc_new      = NFC_W'(1) << root_new;
  assign code_mask   = (CODE_W'(1) << width_now) - CODE_W'(1);
  assign code        = bit_store[CODE_W-1:0] & code_mask;
  assign code_x      = {1'b0, code};
  assign code_eq_nfc = (code_x == next_free_code);
  assign nfc_inc     = next_free_code + NFC_W'(1);
  assign store_full  = ({1'b0, bits_held} + 6'd8) > 6'(STORE_BITS);

  always_comb begin
    if (done) begin
      push_status = ST_END;
    end else if (block_bytes_left == '0) begin
      push_status = ST_TAKEN;
    end else if (!ended && store_full) begin
      push_status = ST_FULL;
    end else begin
      push_status = ST_TAKEN;
    end
  end

  always_comb begin
    stat.item_op     = item_op;
    stat.push_status = push_status;
    stat.ended       = ended;
    stat.done        = done;
    stat.fresh       = fresh;
    stat.stack_empty = (stack_depth == '0);
    stat.stack_full  = (stack_depth == NFC_W'(DEPTH));
    stat.bits_short  = bits_held < {1'b0, width_now};
    stat.code_clear  = (code_x == cc);
    stat.code_end    = (code_x == cc + NFC_W'(1));
    stat.code_ge_cc2 = (code_x >= cc + NFC_W'(2));
    stat.code_gt_nfc = (code_x > next_free_code);
    stat.cur_ge_cc   = ({1'b0, cur} >= cc);
    stat.self_ptr    = (pre_rdata == cur);
  end

  assign consume = (cmd.op == DP_CLEAR) || (cmd.op == DP_END) || (cmd.op == DP_CONSUME) ||
                   (cmd.op == DP_FIRST) || (cmd.op == DP_EXPAND);

  always_comb begin
    stk_we    = 1'b0;
    stk_wdata = first_char;
    unique case (cmd.op)
      DP_EXPAND: begin
        stk_we    = code_eq_nfc;
        stk_wdata = first_char;
      end
      DP_WALK_STEP: begin
        stk_we    = 1'b1;
        stk_wdata = suf_rdata;
      end
      DP_WALK_ROOT: begin
        stk_we    = 1'b1;
        stk_wdata = cur[BYTE_W-1:0];
      end
      default: begin
        stk_we    = 1'b0;
      end
    endcase
  end

  assign tbl_we = (cmd.op == DP_WALK_ROOT) && (next_free_code < TABLE_TOP);

  gld_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stack_depth[CODE_W-1:0]),
    .wdata (stk_wdata),
    .raddr (stack_depth[CODE_W-1:0] - CODE_W'(1)),
    .rdata (stk_rdata)
  );

  gld_ram #(.WIDTH(CODE_W), .DEPTH(DEPTH)) u_prefix (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (next_free_code[CODE_W-1:0]),
    .wdata (old_code),
    .raddr (cur),
    .rdata (pre_rdata)
  );

  gld_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_suffix (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (next_free_code[CODE_W-1:0]),
    .wdata (cur[BYTE_W-1:0]),
    .raddr (cur),
    .rdata (suf_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_code_size <= ROOT_MAX;
    end else if (cfg_we) begin
      min_code_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root             <= ROOT_MAX;
      item_op          <= OP_START;
      bit_store        <= '0;
      bits_held        <= '0;
      block_bytes_left <= '0;
      width_now        <= ROOT_MAX + MCS_W'(1);
      next_free_code   <= (NFC_W'(1) << ROOT_MAX) + NFC_W'(2);
      width_limit      <= NFC_W'(1) << (ROOT_MAX + MCS_W'(1));
      first_char       <= '0;
      old_code         <= '0;
      stack_depth      <= '0;
      fresh            <= 1'b1;
      done             <= 1'b0;
      ended            <= 1'b0;
      status_q         <= '0;
    end else begin
      if (consume) begin
        bit_store <= bit_store >> width_now;
        bits_held <= bits_held - {1'b0, width_now};
      end
      unique case (cmd.op)
        DP_LATCH: begin
          item_op <= opcode_t'(opcode);
        end
        DP_START: begin
          root             <= root_new;
          bit_store        <= '0;
          bits_held        <= '0;
          block_bytes_left <= '0;
          first_char       <= '0;
          old_code         <= '0;
          done             <= 1'b0;
          ended            <= 1'b0;
          fresh            <= 1'b1;
          width_now        <= root_new + MCS_W'(1);
          width_limit      <= cc_new << 1;
          next_free_code   <= cc_new + NFC_W'(2);
          stack_depth      <= '0;
        end
        DP_PUSH: begin
          if (!done) begin
            if (block_bytes_left == '0) begin
              if (item_byte == '0) begin
                done <= 1'b1;
              end else begin
                block_bytes_left <= item_byte;
              end
            end else if (ended) begin
              block_bytes_left <= block_bytes_left - BYTE_W'(1);
            end else if (!store_full) begin
              bit_store        <= bit_store | (STORE_BITS'(item_byte) << bits_held);
              bits_held        <= bits_held + HELD_W'(8);
              block_bytes_left <= block_bytes_left - BYTE_W'(1);
            end
          end
        end
        DP_POP: begin
          stack_depth <= stack_depth - NFC_W'(1);
        end
        DP_CLEAR: begin
          width_now      <= root + MCS_W'(1);
          width_limit    <= cc << 1;
          next_free_code <= cc + NFC_W'(2);
          stack_depth    <= '0;
          fresh          <= 1'b1;
        end
        DP_END: begin
          ended <= 1'b1;
        end
        DP_FIRST: begin
          first_char <= code[BYTE_W-1:0];
          old_code   <= code;
          fresh      <= 1'b0;
        end
        DP_EXPAND: begin
          exp_code <= code;
          if (code_eq_nfc) begin
            cur         <= old_code;
            stack_depth <= stack_depth + NFC_W'(1);
          end else begin
            cur <= code;
          end
        end
        DP_WALK_STEP: begin
          cur         <= pre_rdata;
          stack_depth <= stack_depth + NFC_W'(1);
        end
        DP_WALK_ROOT: begin
          first_char  <= cur[BYTE_W-1:0];
          stack_depth <= stack_depth + NFC_W'(1);
          old_code    <= exp_code;
          if (next_free_code < TABLE_TOP) begin
            next_free_code <= nfc_inc;
            if (nfc_inc >= width_limit && width_limit < TABLE_TOP) begin
              width_limit <= width_limit << 1;
              width_now   <= width_now + MCS_W'(1);
            end
          end
        end
        DP_FLUSH: begin
          stack_depth <= '0;
        end
        default: begin
        end
      endcase
      if (cmd.load_out) begin
        status_q <= res_status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LATCH) begin
      item_byte <= data_byte;
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_code;
      unique case (cmd.pix_sel)
        PIX_CODE:  res_pixel <= code[BYTE_W-1:0];
        PIX_STACK: res_pixel <= stk_rdata;
        default:   res_pixel <= '0;
      endcase
    end
    if (cmd.load_out) begin
      pixel_q <= res_pixel;
    end
  end

  assign status = status_q;
  assign pixel  = pixel_q;

endmodule

>>> rtl/core/gld_ctrl.sv
module gld_ctrl import gld_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  gld_stat_t stat,
  output gld_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_PULL     = 7'b0000100,
    S_POP      = 7'b0001000,
    S_WALK     = 7'b0010000,
    S_WALK_RD  = 7'b0100000,
    S_RESULT   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_comb begin
    cmd.op       = DP_IDLE;
    cmd.set_res  = 1'b0;
    cmd.res_code = ST_TAKEN;
    cmd.pix_sel  = PIX_ZERO;
    cmd.load_out = 1'b0;
    state_next   = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = DP_LATCH;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.item_op)
          OP_START: begin
            cmd.op       = DP_START;
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_TAKEN;
          end
          OP_PUSH: begin
            cmd.op       = DP_PUSH;
            cmd.set_res  = 1'b1;
            cmd.res_code = stat.push_status;
          end
          OP_PULL: begin
            state_next = S_PULL;
          end
          default: begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_ERROR;
          end
        endcase
      end
      S_PULL: begin
        priority if (stat.ended) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_END;
        end else if (!stat.stack_empty) begin
          cmd.op     = DP_POP;
          state_next = S_POP;
        end else if (stat.bits_short) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = stat.done ? ST_ERROR : ST_NEED;
        end else if (stat.code_clear) begin
          cmd.op = DP_CLEAR;
        end else if (stat.code_end) begin
          cmd.op       = DP_END;
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_END;
        end else if (stat.fresh && stat.code_ge_cc2) begin
          cmd.op       = DP_CONSUME;
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_ERROR;
        end else if (stat.fresh) begin
          cmd.op       = DP_FIRST;
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_PIXEL;
          cmd.pix_sel  = PIX_CODE;
        end else if (stat.code_gt_nfc) begin
          cmd.op       = DP_CONSUME;
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_ERROR;
        end else begin
          cmd.op     = DP_EXPAND;
          state_next = S_WALK;
        end
      end
      S_POP: begin
        cmd.set_res  = 1'b1;
        cmd.res_code = ST_PIXEL;
        cmd.pix_sel  = PIX_STACK;
      end
      S_WALK: begin
        priority if (stat.cur_ge_cc) begin
          state_next = S_WALK_RD;
        end else if (stat.stack_full) begin
          cmd.op       = DP_FLUSH;
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_ERROR;
        end else begin
          cmd.op     = DP_WALK_ROOT;
          state_next = S_PULL;
        end
      end
      S_WALK_RD: begin
        if (stat.stack_full || stat.self_ptr) begin
          cmd.op       = DP_FLUSH;
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_ERROR;
        end else begin
          cmd.op     = DP_WALK_STEP;
          state_next = S_WALK;
        end
      end
      S_RESULT: begin
        if (!(out_valid && out_stall)) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (cmd.set_res) begin
      state_next = S_RESULT;
    end
  end

  assign out_valid_next = cmd.load_out | (out_valid & out_stall);
  assign in_stall       = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTH
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("result loaded over an unaccepted item");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_DISPATCH))
    else $error("accepted item not dispatched");

  a_result_next: assert property (@(posedge clk) disable iff (rst)
    cmd.set_res |=> (state == S_RESULT))
    else $error("result set without moving to delivery");
`endif

endmodule

>>> rtl/core/gif_lzw_decoder.sv
// Steps: each item is latched on acceptance and dispatched; a start, push or unused opcode
// then has its result registered. A pull that pops a held pixel passes the pull, pop and
// result states; one that decodes a new code expands it, walks the prefix chain (one RAM read
// and one stack write per table pixel) and pushes the root literal; a clear code adds a pull.
// Throughput: one item in flight; the next is accepted once the result is registered.
// Reset (rst, synchronous) acts as a start with a minimum code size of eight; the table
// and stack RAMs are not cleared, since literal entries are generated and others written first.
module gif_lzw_decoder import gld_pkg::*; #(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [MCS_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        opcode,
  input  logic [BYTE_W-1:0] data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic [BYTE_W-1:0] pixel
);

  // The controller sequences each item: it dispatches on the opcode, runs the
  // pull loop (pop, clear code, end code, first code, expansion) and walks the
  // prefix chain one entry at a time. The datapath holds the bit store, the
  // code tables in RAM, the pixel stack and the result registers.
  gld_cmd_t  cmd;
  gld_stat_t stat;

  gld_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The minimum code size register lives in the datapath and is latched into
  // the working root width only by a start item or by reset.
  gld_datapath #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .opcode    (opcode),
    .data_byte (data_byte),
    .cmd       (cmd),
    .stat      (stat),
    .status    (status),
    .pixel     (pixel)
  );

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import gld_pkg::*;

  // Clock, reset and the ports of the block. Every input starts at a known value.
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [MCS_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        opcode = OP_START;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        status;
  logic [BYTE_W-1:0] pixel;

  gif_lzw_decoder dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .pixel(pixel)
  );

  always #5 clk = ~clk;

  // One expected answer per accepted item: the status and, for a pixel, its colour index.
  typedef struct {
    status_t     st;
    logic [7:0]  pix;
  } answer_t;

  answer_t answers_due[$];
  int      n_items = 0;
  int      n_errors = 0;
  byte unsigned stream_q[$];
  status_t st_dummy;

  // Decoder state as the block should hold it. The code tables, the pixel LIFO,
  // the bit store and the sub-block counter mirror the hardware one to one.
  logic [11:0] tbl_prefix [4096];
  logic [7:0]  tbl_suffix [4096];
  logic [7:0]  lifo [4096];
  int          lifo_depth, store, held, block_left, width, free_code, limit;
  int          first_ch, prev_code, root;
  bit          fresh, done, ended;
  logic [3:0]  code_size_reg = 4'd8;

  function automatic int clear_val();
    return 1 << root;
  endfunction

  function automatic void clear_tables();
    int cc;
    cc = clear_val();
    for (int i = 0; i < 4096; i++) begin
      tbl_prefix[i] = '0;
      tbl_suffix[i] = (i < cc) ? 8'(i) : 8'd0;
    end
    width = root + 1;
    limit = 2 * cc;
    free_code = cc + 2;
    lifo_depth = 0;
    fresh = 1'b1;
  endfunction

  // A start latches the code size, clamped into the legal range of two to eight.
  function automatic void decoder_start();
    root = code_size_reg < 2 ? 2 : (code_size_reg > 8 ? 8 : int'(code_size_reg));
    store = 0;
    held = 0;
    block_left = 0;
    first_ch = 0;
    prev_code = 0;
    done = 1'b0;
    ended = 1'b0;
    clear_tables();
  endfunction

  function automatic bit lifo_push(int v);
    if (lifo_depth >= 4096) return 1'b0;
    lifo[lifo_depth] = 8'(v);
    lifo_depth++;
    return 1'b1;
  endfunction

  function automatic status_t take_byte(logic [7:0] b);
    if (done) return ST_END;
    if (block_left == 0) begin
      if (b == 0) done = 1'b1;
      else block_left = b;
      return ST_TAKEN;
    end
    // After the end code the payload is only counted off, never stored.
    if (!ended) begin
      if (held + 8 > STORE_BITS) return ST_FULL;
      store = (store | (int'(b) << held)) & 24'hFFFFFF;
      held += 8;
    end
    block_left--;
    return ST_TAKEN;
  endfunction

  // Walks the prefix chain of one code onto the LIFO and adds the new table entry.
  function automatic bit expand_code(int code);
    int cur;
    cur = code;
    if (code == free_code) begin
      // The string of the code being defined: previous string plus its own first pixel.
      if (!lifo_push(first_ch)) return 1'b0;
      cur = prev_code;
    end
    while (cur >= clear_val()) begin
      cur &= 4095;
      if (!lifo_push(tbl_suffix[cur])) return 1'b0;
      if (tbl_prefix[cur] == cur) return 1'b0;
      cur = tbl_prefix[cur];
    end
    first_ch = tbl_suffix[cur];
    if (!lifo_push(first_ch)) return 1'b0;
    if (free_code < 4096) begin
      tbl_prefix[free_code] = 12'(prev_code);
      tbl_suffix[free_code] = 8'(first_ch);
      free_code++;
      if (free_code >= limit && limit < 4096) begin
        limit <<= 1;
        width++;
      end
    end
    prev_code = code;
    return 1'b1;
  endfunction

  function automatic status_t pull_one(output logic [7:0] pix);
    int code, cc;
    pix = '0;
    forever begin
      cc = clear_val();
      if (ended) return ST_END;
      if (lifo_depth > 0) begin
        lifo_depth--;
        pix = lifo[lifo_depth];
        return ST_PIXEL;
      end
      if (held < width) return done ? ST_ERROR : ST_NEED;
      code = store & ((1 << width) - 1);
      store >>= width;
      held -= width;
      if (code == cc) begin
        clear_tables();
        continue;
      end
      if (code == cc + 1) begin
        ended = 1'b1;
        return ST_END;
      end
      if (fresh) begin
        if (code >= cc + 2) return ST_ERROR;
        first_ch = code;
        prev_code = code;
        fresh = 1'b0;
        pix = 8'(code);
        return ST_PIXEL;
      end
      if (code > free_code) return ST_ERROR;
      if (!expand_code(code)) begin
        lifo_depth = 0;
        return ST_ERROR;
      end
    end
  endfunction

  function automatic answer_t decode_item(opcode_t op, logic [7:0] b);
    answer_t a;
    a.pix = '0;
    case (op)
      OP_START: begin
        decoder_start();
        a.st = ST_TAKEN;
      end
      OP_PUSH: a.st = take_byte(b);
      OP_PULL: a.st = pull_one(a.pix);
      default: a.st = ST_ERROR;
    endcase
    if (a.st != ST_PIXEL) a.pix = '0;
    return a;
  endfunction

  // Idling is heavy on the receiving side first, then on the sending side, then absent.
  function automatic int send_gap_pct();
    return n_items < 400 ? 37 : (n_items < 800 ? 46 : 0);
  endfunction

  function automatic int recv_gap_pct();
    return n_items < 400 ? 46 : (n_items < 800 ? 37 : 0);
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_gap_pct());
  end

  // Each accepted result is compared with the oldest answer still waiting.
  always @(posedge clk) begin
    answer_t a;
    if (!rst && out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d pixel %0d",
                 $time, status, pixel);
        n_errors++;
      end else begin
        a = answers_due.pop_front();
        if (status !== a.st) begin
          $display("%0t: status mismatch: expected %0d, actual %0d", $time, a.st, status);
          n_errors++;
        end
        if (pixel !== a.pix) begin
          $display("%0t: pixel mismatch: expected %0d, actual %0d", $time, a.pix, pixel);
          n_errors++;
        end
      end
    end
  end

  // Sends one item, waits for it to be taken, and hands back the status it should get,
  // so that the stimulus can steer pushes and pulls the way a real consumer would.
  task automatic send_item(opcode_t op, logic [7:0] b, output status_t st);
    answer_t a;
    if ($urandom_range(99) < send_gap_pct()) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    a = decode_item(op, b);
    answers_due.push_back(a);
    n_items++;
    st = a.st;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    // The decoder is then left idle before anything else is touched.
    repeat (20) @(posedge clk);
  endtask

  // The code size is only written with the decoder idle, and a start item follows it.
  task automatic load_code_size(logic [3:0] v);
    status_t st;
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    code_size_reg = v;
    send_item(OP_START, 8'd0, st);
  endtask

  // Builds a well-formed image-data stream of random codes, tracking the code width
  // exactly as the decoder grows it, then cuts it into sub-blocks with a terminator.
  task automatic build_stream(int n_codes, int lit_pct, int blk_max);
    byte unsigned payload[$];
    longint acc;
    int nb, cc, w, nf, lim, code, r, len;
    bit fr;
    r = code_size_reg < 2 ? 2 : (code_size_reg > 8 ? 8 : int'(code_size_reg));
    cc = 1 << r;
    acc = 0;
    nb = 0;
    code = cc;
    fr = 1'b1;
    w = r + 1;
    nf = cc + 2;
    lim = 2 * cc;
    for (int i = 0; i <= n_codes + 1; i++) begin
      if (i == n_codes + 1) code = cc + 1;
      else if (i > 0) begin
        if (!fr && $urandom_range(99) < 2) code = cc;
        else if (fr || $urandom_range(99) < lit_pct) code = $urandom_range(cc - 1);
        else code = $urandom_range(nf > 4095 ? 4095 : nf, cc + 2);
      end
      acc |= longint'(code) << nb;
      nb += w;
      while (nb >= 8) begin
        payload.push_back(byte'(acc & 8'hFF));
        acc >>= 8;
        nb -= 8;
      end
      if (code == cc) begin
        fr = 1'b1;
        w = r + 1;
        nf = cc + 2;
        lim = 2 * cc;
      end else if (fr) fr = 1'b0;
      else if (nf < 4096) begin
        nf++;
        if (nf >= lim && lim < 4096) begin
          lim <<= 1;
          w++;
        end
      end
    end
    if (nb > 0) payload.push_back(byte'(acc & 8'hFF));
    stream_q.delete();
    while (payload.size() > 0) begin
      len = $urandom_range(blk_max, 1);
      if (len > payload.size()) len = payload.size();
      stream_q.push_back(byte'(len));
      repeat (len) stream_q.push_back(payload.pop_front());
    end
    stream_q.push_back(8'd0);
  endtask

  task automatic drain_pixels();
    status_t st;
    do send_item(OP_PULL, 8'd0, st); while (st == ST_PIXEL);
  endtask

  // Feeds the stream and pulls pixels whenever the store is full or at random,
  // then pulls to the end code and one step past it.
  task automatic play_stream();
    status_t st;
    int i;
    i = 0;
    while (i < stream_q.size()) begin
      if ($urandom_range(99) < 20) drain_pixels();
      send_item(OP_PUSH, stream_q[i], st);
      if (st == ST_FULL) drain_pixels();
      else i++;
    end
    drain_pixels();
    send_item(OP_PULL, 8'd0, st);
  endtask

  // Opcode three, an empty store, a full store, a first code that is no literal,
  // a push past the terminator and a truncated stream.
  task automatic test_special_cases();
    status_t st;
    send_item(OP_NONE, 8'hFF, st);
    send_item(OP_PULL, 8'd0, st);
    send_item(OP_PUSH, 8'd4, st);
    send_item(OP_PUSH, 8'hFF, st);
    send_item(OP_PUSH, 8'h00, st);
    send_item(OP_PUSH, 8'hAA, st);
    send_item(OP_PUSH, 8'h55, st);
    repeat (3) send_item(OP_PULL, 8'd0, st);
    send_item(OP_PUSH, 8'h55, st);
    send_item(OP_PUSH, 8'd0, st);
    send_item(OP_PUSH, 8'd0, st);
    send_item(OP_PUSH, 8'h80, st);
    repeat (3) send_item(OP_PULL, 8'd0, st);
    send_item(OP_START, 8'd0, st);
    send_item(OP_PUSH, 8'd2, st);
    send_item(OP_PUSH, 8'h01, st);
    send_item(OP_PUSH, 8'h00, st);
    send_item(OP_PUSH, 8'd0, st);
    repeat (3) send_item(OP_PULL, 8'd0, st);
  endtask

  // Short well-formed streams at code sizes 2, 3, 5, 7 and 8, and at the out-of-range values 0, 1, 9 and 15.
  task automatic test_streams();
    logic [3:0] sizes[$] = '{4'd8, 4'd2, 4'd0, 4'd15, 4'd5, 4'd1, 4'd9, 4'd3, 4'd7};
    foreach (sizes[k]) begin
      load_code_size(sizes[k]);
      repeat (2) begin
        build_stream($urandom_range(14, 4), $urandom_range(80, 20), $urandom_range(12, 1));
        play_stream();
        send_item(OP_START, 8'd0, st_dummy);
      end
    end
  endtask

  // Random items of every kind, so codes past the free code and bad first codes turn up.
  task automatic test_noise();
    status_t st;
    int r;
    repeat (150) begin
      r = $urandom_range(99);
      if (r < 3) send_item(OP_START, 8'($urandom), st);
      else if (r < 6) send_item(OP_NONE, 8'($urandom), st);
      else if (r < 55) send_item(OP_PUSH, 8'($urandom), st);
      else send_item(OP_PULL, 8'($urandom), st);
    end
  endtask

  // A longer stream at the smallest code size, so that the code width grows several times.
  task automatic test_width_growth();
    load_code_size(4'd2);
    build_stream(60, 40, 255);
    play_stream();
  endtask

  initial begin
    decoder_start();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_cases();
    test_streams();
    load_code_size(4'd6);
    test_noise();
    test_width_growth();
    load_code_size(4'd8);
    build_stream(50, 50, 255);
    play_stream();
    send_item(OP_START, 8'd0, st_dummy);
    wait_idle();
    if (n_errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
